FILE: hw/rtl/xeis_pkg.sv
package xeis_pkg;

   localparam int DEFAULT_VALUE_BITS = 64;
   localparam int DEFAULT_ENTRIES    = 64;
   localparam int IDX_BITS           = 6;
   localparam int DATA_BITS          = 64;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [IDX_BITS-1:0]  entry_index;
      logic [DATA_BITS-1:0] entry_value;
      logic                 find_max;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] best_index;
      logic                table_empty;
   } rsp_type;

   // classified request handed from the front queue to the execution side
   typedef struct packed {
      logic [1:0]           cmd;
      logic [IDX_BITS-1:0]  entry_index;
      logic                 in_range;
      logic [DATA_BITS-1:0] entry_value;
      logic                 find_max;
   } job_type;

endpackage

FILE: hw/rtl/xeis_front.sv
module xeis_front #(
   parameter int ENTRIES = xeis_pkg::DEFAULT_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xeis_pkg::req_type req_payload,
   output logic              job_valid,
   input  logic              job_pop,
   output xeis_pkg::job_type job
);
   import xeis_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type         q_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   job_type         job_new;
   logic            push;
   logic            pop;

   always_comb begin
      job_new.cmd         = req_payload.cmd;
      job_new.entry_index = req_payload.entry_index;
      job_new.in_range    = (32'(req_payload.entry_index) < ENTRIES);
      job_new.entry_value = req_payload.entry_value;
      job_new.find_max    = req_payload.find_max;
   end

   assign req_ready = (count_ff != (PW+1)'(QUEUE_DEPTH));
   assign job_valid = (count_ff != '0);
   assign job       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_pop && job_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

FILE: hw/rtl/xeis_back.sv
module xeis_back #(
   parameter int VALUE_BITS = xeis_pkg::DEFAULT_VALUE_BITS,
   parameter int ENTRIES    = xeis_pkg::DEFAULT_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_pop,
   input  xeis_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xeis_pkg::rsp_type rsp_payload
);
   import xeis_pkg::*;

   // only indexes the request field can reach are ever stored
   localparam int SLOTS = (ENTRIES < (1 << IDX_BITS)) ? ENTRIES : (1 << IDX_BITS);
   localparam int AW    = $clog2(SLOTS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [VALUE_BITS-1:0] mem [SLOTS];
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic [1:0]            state_ff, state_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] qval_ff;
   logic                  qmax_ff;
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic                  rd_live_ff, rd_live_in;
   logic [AW-1:0]         rd_idx_ff;
   logic                  found_ff, found_in;
   logic [VALUE_BITS-1:0] best_x_ff, best_x_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [VALUE_BITS-1:0] x;
   logic                  better;
   logic                  start;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;

   assign start   = (state_ff == S_IDLE) && job_valid && !rsp_valid_ff;
   assign job_pop = start;
   assign wr_addr = job.entry_index[AW-1:0];
   assign wr_en   = start && (job.cmd == CMD_INSERT) && job.in_range;

   assign x      = rd_data_ff ^ qval_ff;
   assign better = !found_ff || (qmax_ff ? (x > best_x_ff) : (x < best_x_ff));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      found_in     = found_ff;
      best_x_in    = best_x_ff;
      best_idx_in  = best_idx_ff;
      rd_live_in   = (state_ff == S_SCAN) && valid_ff[cnt_ff];

      // candidate elimination, one stored entry per cycle
      if (rd_live_ff && better) begin
         found_in    = 1'b1;
         best_x_in   = x;
         best_idx_in = rd_idx_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in.best_index  = '0;
               rsp_in.table_empty = 1'b0;
               case (job.cmd)
                  CMD_INSERT: begin
                     if (job.in_range) valid_in[wr_addr] = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_REMOVE: begin
                     if (job.in_range) valid_in[wr_addr] = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_QUERY: begin
                     cnt_in   = '0;
                     found_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(SLOTS - 1)) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            rsp_valid_in       = 1'b1;
            rsp_in.best_index  = found_ff ? IDX_BITS'(best_idx_ff) : '0;
            rsp_in.table_empty = !found_ff;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_live_ff   <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff   <= rd_live_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
      best_x_ff   <= best_x_in;
      best_idx_ff <= best_idx_in;
      rd_idx_ff   <= cnt_ff;
      if (start) begin
         qval_ff <= job.entry_value[VALUE_BITS-1:0];
         qmax_ff <= job.find_max;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= job.entry_value[VALUE_BITS-1:0];
      end
      rd_data_ff <= mem[cnt_ff];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/xor_extreme_index_search.sv
// insert, remove and unused commands: result registered when the command leaves the queue
// query: the result follows a scan of all min(ENTRIES,64) slots of the value memory,
// one stored entry per cycle, then the drain and finish states
// a new command starts only when the previous response has been taken; a 2-deep
// request queue accepts while one executes
// synchronous active-high reset empties the table and the queue; no clearing pass
module xor_extreme_index_search #(
   parameter int VALUE_BITS = xeis_pkg::DEFAULT_VALUE_BITS,
   parameter int ENTRIES    = xeis_pkg::DEFAULT_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xeis_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xeis_pkg::rsp_type rsp_payload
);
   import xeis_pkg::*;

   logic    job_valid;
   logic    job_pop;
   job_type job;

   xeis_front #(
      .ENTRIES(ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .job_valid  (job_valid),
      .job_pop    (job_pop),
      .job        (job)
   );

   xeis_back #(
      .VALUE_BITS(VALUE_BITS),
      .ENTRIES   (ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_pop    (job_pop),
      .job        (job),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

FILE: bench/xeis_checker.sv
module xeis_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  xeis_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  xeis_pkg::rsp_type rsp_payload,
   output int                error_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import xeis_pkg::*;

   logic [63:0]    slot_valid;
   logic [63:0]    slot_value [64];
   rsp_type        expected_rsp [$];

   function automatic rsp_type search_table(req_type r);
      rsp_type     o;
      logic [63:0] x, best_x;
      logic        found;
      o = '0;
      found = 1'b0;
      best_x = '0;
      for (int i = 0; i < 64; i++) begin
         if (slot_valid[i]) begin
            x = slot_value[i] ^ r.entry_value;
            if (!found || (r.find_max ? (x > best_x) : (x < best_x))) begin
               found = 1'b1;
               best_x = x;
               o.best_index = i[5:0];
            end
         end
      end
      o.table_empty = !found;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         slot_valid = '0;
         expected_rsp.delete();
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected response: index %0d empty %0b",
                           rsp_payload.best_index, rsp_payload.table_empty);
               error_count <= error_count + 1;
            end else begin
               e = expected_rsp.pop_front();
               if (e !== rsp_payload) begin
                  if (error_count < 10)
                     $display("mismatch: expected index %0d empty %0b, got index %0d empty %0b",
                              e.best_index, e.table_empty,
                              rsp_payload.best_index, rsp_payload.table_empty);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            e = '0;
            case (req_payload.cmd)
               CMD_INSERT: begin
                  slot_valid[req_payload.entry_index] = 1'b1;
                  slot_value[req_payload.entry_index] = req_payload.entry_value;
               end
               CMD_REMOVE: slot_valid[req_payload.entry_index] = 1'b0;
               CMD_QUERY:  e = search_table(req_payload);
               default: ;
            endcase
            expected_rsp.push_back(e);
         end
         pending_count <= expected_rsp.size();
      end
   end
endmodule

FILE: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import xeis_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   int      error_count, pending_count;
   int      sender_idle_pct = 0, receiver_stall_pct = 0;
   int      quiet_cycles = 0;
   logic [63:0] recent_values [8];

   always #5 clock = ~clock;

   xor_extreme_index_search uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   xeis_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .error_count(error_count), .pending_count(pending_count)
   );

   always @(posedge clock) begin
      if (!reset)
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send_request(logic [1:0] cmd, logic [5:0] idx, logic [63:0] value,
                               logic find_max);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{cmd: cmd, entry_index: idx, entry_value: value, find_max: find_max};
      // ready is stable between edges, so look at it mid-cycle
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // random values, often equal or close to earlier ones, so queries hit close xor ties
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(3))
         0: v = {$urandom, $urandom};
         1: v = recent_values[$urandom_range(7)] ^ (64'd1 << $urandom_range(63));
         2: v = recent_values[$urandom_range(7)];
         default: v = {$urandom_range(1) ? 32'hffffffff : 32'h0, 28'h0, 4'($urandom)};
      endcase
      recent_values[$urandom_range(7)] = v;
      return v;
   endfunction

   task automatic random_phase(int count, int idle_pct, int stall_pct);
      logic [1:0] cmd;
      int         r;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         cmd = (r < 40) ? CMD_INSERT : (r < 55) ? CMD_REMOVE : (r < 97) ? CMD_QUERY : CMD_UNUSED;
         send_request(cmd, 6'($urandom_range(63)), pick_value(), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) recent_values[i] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, ties, removal, unused command
      send_request(CMD_QUERY, 6'd5, 64'h0, 1'b0);
      send_request(CMD_QUERY, 6'd0, '1, 1'b1);
      send_request(CMD_REMOVE, 6'd9, 64'h0, 1'b0);
      send_request(CMD_INSERT, 6'd63, '1, 1'b0);
      send_request(CMD_INSERT, 6'd0, 64'h0, 1'b0);
      send_request(CMD_QUERY, 6'd0, '1, 1'b0);
      send_request(CMD_QUERY, 6'd0, '1, 1'b1);
      send_request(CMD_INSERT, 6'd40, '1, 1'b0);
      send_request(CMD_QUERY, 6'd0, 64'h0, 1'b1);
      send_request(CMD_INSERT, 6'd20, 64'h8000_0000_0000_0000, 1'b1);
      send_request(CMD_QUERY, 6'd33, 64'h0, 1'b0);
      send_request(CMD_QUERY, 6'd33, 64'h7fff_ffff_ffff_ffff, 1'b1);
      send_request(CMD_UNUSED, 6'd63, '1, 1'b1);
      send_request(CMD_INSERT, 6'd0, 64'h5555_5555_5555_5555, 1'b0);
      send_request(CMD_QUERY, 6'd1, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
      send_request(CMD_REMOVE, 6'd63, 64'h0, 1'b0);
      send_request(CMD_REMOVE, 6'd63, 64'h0, 1'b0);
      send_request(CMD_REMOVE, 6'd0, 64'h0, 1'b0);
      send_request(CMD_REMOVE, 6'd40, 64'h0, 1'b0);
      send_request(CMD_QUERY, 6'd0, 64'h1, 1'b0);
      send_request(CMD_REMOVE, 6'd20, 64'h0, 1'b0);
      send_request(CMD_QUERY, 6'd0, 64'h1, 1'b1);
      drain_responses();

      random_phase(180, 0, 0);
      random_phase(170, 53, 0);
      drain_responses();
      random_phase(170, 0, 53);
      random_phase(170, 12, 12);
      drain_responses();
      repeat (100) @(posedge clock);

      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule

FILE: files.f
hw/rtl/xeis_pkg.sv
hw/rtl/xeis_front.sv
hw/rtl/xeis_back.sv
hw/rtl/xor_extreme_index_search.sv
bench/xeis_checker.sv
bench/tb_top.sv
